// ----- rtl/core/lpmd_pkg.sv -----
// Package for the length-prefixed message deframer: constants, codes and the result type.
`default_nettype none

package lpmd_pkg;

  localparam int unsigned HdrBytes = 10;
  localparam int unsigned LenBytes = 4;
  localparam int unsigned CntW = 32;
  localparam int unsigned LenW = 32;
  localparam logic [LenW-1:0] MaxFrameReset = 32'h0010_0000;
  localparam int unsigned OutDataW = 128;

  typedef enum logic [1:0] {
    PhLen  = 2'd0,
    PhHdr  = 2'd1,
    PhBody = 2'd2
  } phase_e;

  typedef enum logic [1:0] {
    KindHeader = 2'd0,
    KindBody   = 2'd1,
    KindError  = 2'd2
  } kind_e;

  typedef enum logic {
    ErrTooShort = 1'b0,
    ErrTooLong  = 1'b1
  } err_e;

  typedef struct packed {
    kind_e       kind;
    logic [15:0] conn_id;
    logic [7:0]  header_byte_two;
    logic [7:0]  header_byte_three;
    logic [7:0]  presentation_type;
    logic [7:0]  session_type;
    logic [31:0] txn_tag;
    logic [31:0] body_length;
    logic [7:0]  body_byte;
    logic        last;
    err_e        error_code;
  } res_t;

endpackage

`default_nettype wire

// ----- rtl/core/length_prefixed_message_deframer.sv -----
// Length-prefixed message deframer: length check, header gather and body pass-through.
//
// Channel    Dir  tdata fields (low bit up)                         tuser / tlast
// s_axis     in   data_byte[7:0]                                    -
// m_axis     out  conn_id, header_byte_two, header_byte_three,      kind / last
//                 presentation_type, session_type, txn_tag,
//                 body_length, body_byte, error_code, zero pad
// cfg        in   max_frame_length[31:0] on cfg_we_i                -
//
// One item per cycle while s_axis_tready_o is high: each input item is decoded
// combinationally against the phase and count registers, and any result it gives is registered.
// A skid register behind the output register lets one more item in while a
// result is stalled; s_axis_tready_o is low only while the skid is full.
// Reset clears phase, counts, error latch and the limit (to 1048576).
// An error latches until reset; every later item then gives an error result.
`default_nettype none

module length_prefixed_message_deframer
  import lpmd_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [LenW-1:0]     cfg_wdata_i,     // max_frame_length
  input  wire logic                s_axis_tvalid_i,
  output      logic                s_axis_tready_o,
  input  wire logic [7:0]          s_axis_tdata_i,  // data_byte[7:0]
  output      logic                m_axis_tvalid_o,
  input  wire logic                m_axis_tready_i,
  // conn_id[15:0], header_byte_two[23:16], header_byte_three[31:24],
  // presentation_type[39:32], session_type[47:40], txn_tag[79:48],
  // body_length[111:80], body_byte[119:112], error_code[120], zero[127:121]
  output      logic [OutDataW-1:0] m_axis_tdata_o,
  output      logic [1:0]          m_axis_tuser_o,  // kind[1:0]
  output      logic                m_axis_tlast_o
);

  logic [LenW-1:0] max_q;
  phase_e          phase_q, phase_d;
  logic [CntW-1:0] cnt_q, cnt_d, cnt_inc;
  logic [LenW-1:0] len_q, len_d, len_shift;
  logic [71:0]     hdr_q, hdr_d;
  logic            failed_q, failed_d;
  err_e            err_q, err_d;

  res_t            res;
  logic            res_vld;
  logic            s_fire;

  res_t            out_q, skid_q;
  logic            out_vld_q, skid_vld_q;

  assign s_axis_tready_o = !skid_vld_q;
  assign s_fire          = s_axis_tvalid_i && s_axis_tready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q <= MaxFrameReset;
    end else if (cfg_we_i) begin
      max_q <= cfg_wdata_i;
    end
  end

  always_comb begin
    phase_d   = phase_q;
    cnt_d     = cnt_q;
    len_d     = len_q;
    hdr_d     = hdr_q;
    failed_d  = failed_q;
    err_d     = err_q;
    res       = '0;
    res_vld   = 1'b0;
    cnt_inc   = cnt_q + CntW'(1);
    len_shift = {len_q[LenW-9:0], s_axis_tdata_i};
    if (s_fire) begin
      if (failed_q) begin
        res_vld        = 1'b1;
        res.kind       = KindError;
        res.error_code = err_q;
      end else begin
        case (phase_q)
          PhHdr: begin
            hdr_d = {hdr_q[63:0], s_axis_tdata_i};
            cnt_d = cnt_inc;
            if (cnt_q == CntW'(HdrBytes - 1)) begin
              res_vld               = 1'b1;
              res.kind              = KindHeader;
              res.conn_id           = hdr_q[71:56];
              res.header_byte_two   = hdr_q[55:48];
              res.header_byte_three = hdr_q[47:40];
              res.presentation_type = hdr_q[39:32];
              res.session_type      = hdr_q[31:24];
              res.txn_tag           = {hdr_q[23:0], s_axis_tdata_i};
              res.body_length       = len_q;
              res.last              = (len_q == '0);
              cnt_d                 = '0;
              phase_d               = (len_q == '0) ? PhLen : PhBody;
            end
          end
          PhBody: begin
            cnt_d         = cnt_inc;
            res_vld       = 1'b1;
            res.kind      = KindBody;
            res.body_byte = s_axis_tdata_i;
            res.last      = (cnt_inc >= len_q);
            if (cnt_inc >= len_q) begin
              phase_d = PhLen;
              cnt_d   = '0;
              len_d   = '0;
            end
          end
          default: begin
            // len_q gathers the length, then holds the body length
            phase_d = PhLen;
            len_d   = len_shift;
            cnt_d   = cnt_inc;
            if (cnt_q == CntW'(LenBytes - 1)) begin
              cnt_d = '0;
              if (len_shift < LenW'(HdrBytes)) begin
                failed_d       = 1'b1;
                err_d          = ErrTooShort;
                res_vld        = 1'b1;
                res.kind       = KindError;
                res.error_code = ErrTooShort;
              end else if (len_shift > max_q) begin
                failed_d       = 1'b1;
                err_d          = ErrTooLong;
                res_vld        = 1'b1;
                res.kind       = KindError;
                res.error_code = ErrTooLong;
              end else begin
                phase_d = PhHdr;
                len_d   = len_shift - LenW'(HdrBytes);
              end
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PhLen;
      cnt_q    <= '0;
      len_q    <= '0;
      failed_q <= 1'b0;
      err_q    <= ErrTooShort;
    end else begin
      phase_q  <= phase_d;
      cnt_q    <= cnt_d;
      len_q    <= len_d;
      failed_q <= failed_d;
      err_q    <= err_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hdr_q <= hdr_d;
  end

  // hold a stalled result in the output register, park the next one in the skid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (skid_vld_q) begin
      if (m_axis_tready_i) begin
        skid_vld_q <= 1'b0;
      end
    end else if (!out_vld_q || m_axis_tready_i) begin
      out_vld_q <= s_fire && res_vld;
    end else if (s_fire && res_vld) begin
      skid_vld_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_vld_q) begin
      if (m_axis_tready_i) begin
        out_q <= skid_q;
      end
    end else if (!out_vld_q || m_axis_tready_i) begin
      if (s_fire && res_vld) begin
        out_q <= res;
      end
    end else if (s_fire && res_vld) begin
      skid_q <= res;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tuser_o  = out_q.kind;
  assign m_axis_tlast_o  = out_q.last;
  assign m_axis_tdata_o  = {7'd0, out_q.error_code, out_q.body_byte, out_q.body_length,
                            out_q.txn_tag, out_q.session_type, out_q.presentation_type,
                            out_q.header_byte_three, out_q.header_byte_two,
                            out_q.conn_id};

`ifndef NO_ASSERTIONS
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q |-> out_vld_q)
    else $error("skid holds an item while the output register is empty");

  a_error_sticks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    failed_q |=> failed_q && $stable(err_q))
    else $error("latched error changed before reset");

  a_error_in_len_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    failed_q |-> phase_q == PhLen)
    else $error("error latched outside the length phase");

  a_failed_gives_error: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_fire && failed_q |-> res_vld && res.kind == KindError)
    else $error("item after a latched error gave no error result");

  a_body_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PhBody |-> len_q != '0)
    else $error("body phase entered with an empty body");
`endif

endmodule

`default_nettype wire
